/* rtl/point_segment_distance_3d_unit_macros.svh */
// ---------------------------------------------------------------------------
// point_segment_distance_3d_unit_macros.svh
// Assertion helpers used by the edge distance unit.
// ---------------------------------------------------------------------------
`ifndef POINT_SEGMENT_DISTANCE_3D_UNIT_MACROS_SVH
`define POINT_SEGMENT_DISTANCE_3D_UNIT_MACROS_SVH

// same-cycle implication, masked during reset
`define PSD3_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("psd3 same-cycle check failed");

// next-cycle implication, masked during reset
`define PSD3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("psd3 next-cycle check failed");

`endif

/* rtl/psd3_pkg.sv */
// ---------------------------------------------------------------------------
// psd3_pkg
// Widths, register indexes and shared types of the edge distance unit.
// ---------------------------------------------------------------------------
`default_nettype none

package psd3_pkg;

  // coordinate and intermediate widths
  localparam int COORD_W   = 32;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int SQ1_W     = 2 * COORD_W;
  localparam int DOT_W     = PROD_W + 2;
  localparam int SQ_W      = SQ1_W + 2;
  localparam int CROSS_W   = PROD_W;
  localparam int XABS_W    = CROSS_W - 1;
  localparam int XLO_W     = DIFF_W;
  localparam int XHI_W     = XABS_W - XLO_W;
  localparam int XSQ_W     = 2 * XABS_W;
  localparam int XX_W      = XSQ_W + 2;
  localparam int QUO_W     = XX_W / 2;
  localparam int ROOT_W    = QUO_W / 2;
  localparam int REM_W     = ROOT_W + 3;
  localparam int OUT_W     = 34;
  localparam int REG_IDX_W = 3;

  // register stages ahead of the divider
  localparam int FRONT_STAGES = 8;
  // edge distance from accepted start to accepted result
  localparam int PIPE_LAT = FRONT_STAGES + QUO_W + ROOT_W + 1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_START_X = 3'd0,
    REG_START_Y = 3'd1,
    REG_START_Z = 3'd2,
    REG_END_X   = 3'd3,
    REG_END_Y   = 3'd4,
    REG_END_Z   = 3'd5
  } psd3_reg_t;

  // sideband that travels with each item
  typedef struct packed {
    logic valid;
    logic interior;
  } psd3_tag_t;

endpackage

`default_nettype wire

/* rtl/psd3_root_pipe.sv */
// ---------------------------------------------------------------------------
// psd3_root_pipe
// Pipelined restoring divider, one quotient bit per stage, followed by a
// pipelined digit-by-digit square root, one root bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module psd3_root_pipe (
  input  logic                                clk,
  input  logic                                rst_n,
  input  psd3_pkg::psd3_tag_t                 in_tag,
  input  logic [psd3_pkg::XX_W-1:0]           in_num,
  input  logic [psd3_pkg::QUO_W-1:0]          in_den,
  output psd3_pkg::psd3_tag_t                 out_tag,
  output logic [psd3_pkg::ROOT_W-1:0]         out_root
);

  localparam int QW = psd3_pkg::QUO_W;
  localparam int RW = psd3_pkg::ROOT_W;
  localparam int MW = psd3_pkg::REM_W;

  // divider stage registers
  psd3_pkg::psd3_tag_t div_tag_r [QW];
  logic [QW-1:0]       div_rem_r [QW];
  logic [QW-1:0]       div_low_r [QW];
  logic [QW-1:0]       div_den_r [QW];
  logic [QW-1:0]       div_quo_r [QW];

  // root stage registers
  psd3_pkg::psd3_tag_t sq_tag_r  [RW];
  logic [QW-1:0]       sq_rad_r  [RW];
  logic [MW-1:0]       sq_rem_r  [RW];
  logic [RW-1:0]       sq_root_r [RW];

  // divider: the quotient fits QW bits, so the upper numerator half seeds the remainder
  for (genvar k = 0; k < QW; k++) begin : g_div
    psd3_pkg::psd3_tag_t tag_in;
    logic [QW-1:0]       rem_in;
    logic [QW-1:0]       low_in;
    logic [QW-1:0]       den_in;
    logic [QW-1:0]       quo_in;
    logic [QW:0]         sh;
    logic [QW:0]         diff;
    logic                ge;

    if (k == 0) begin : g_first
      assign tag_in = in_tag;
      assign rem_in = in_num[2*QW-1:QW];
      assign low_in = in_num[QW-1:0];
      assign den_in = in_den;
      assign quo_in = '0;
    end else begin : g_next
      assign tag_in = div_tag_r[k-1];
      assign rem_in = div_rem_r[k-1];
      assign low_in = div_low_r[k-1];
      assign den_in = div_den_r[k-1];
      assign quo_in = div_quo_r[k-1];
    end

    // shift in one numerator bit and try the subtract
    assign sh   = {rem_in, low_in[QW-1]};
    assign diff = sh - {1'b0, den_in};
    assign ge   = (sh >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_tag_r[k] <= '0;
      end else begin
        div_tag_r[k] <= tag_in;
      end
    end

    always_ff @(posedge clk) begin
      div_rem_r[k] <= ge ? diff[QW-1:0] : sh[QW-1:0];
      div_low_r[k] <= {low_in[QW-2:0], 1'b0};
      div_den_r[k] <= den_in;
      div_quo_r[k] <= {quo_in[QW-2:0], ge};
    end
  end

  // square root: two radicand bits per stage
  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    psd3_pkg::psd3_tag_t tag_in;
    logic [QW-1:0]       rad_in;
    logic [MW-1:0]       rem_in;
    logic [RW-1:0]       root_in;
    logic [MW-1:0]       rem_sh;
    logic [MW-1:0]       trial;
    logic                ge;

    if (j == 0) begin : g_first
      assign tag_in  = div_tag_r[QW-1];
      assign rad_in  = div_quo_r[QW-1];
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign tag_in  = sq_tag_r[j-1];
      assign rad_in  = sq_rad_r[j-1];
      assign rem_in  = sq_rem_r[j-1];
      assign root_in = sq_root_r[j-1];
    end

    assign rem_sh = {rem_in[MW-3:0], rad_in[QW-1:QW-2]};
    assign trial  = MW'({root_in, 2'b01});
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_tag_r[j] <= '0;
      end else begin
        sq_tag_r[j] <= tag_in;
      end
    end

    always_ff @(posedge clk) begin
      sq_rad_r[j]  <= {rad_in[QW-3:0], 2'b00};
      sq_rem_r[j]  <= ge ? (rem_sh - trial) : rem_sh;
      sq_root_r[j] <= {root_in[RW-2:0], ge};
    end
  end

  assign out_tag  = sq_tag_r[RW-1];
  assign out_root = sq_root_r[RW-1];

endmodule

`default_nettype wire

/* rtl/point_segment_distance_3d_unit.sv */
// A result strobes out_valid after the front stages, the divider, the root pipe and the result register.
// Throughput: one query per cycle; busy stays low and results cannot stall.
// Most of the depth comes from the 66-stage quotient pipeline and the 33-stage root pipeline.
// Reset clears the edge corners to 0 and drops every query in flight.
// ---------------------------------------------------------------------------
// point_segment_distance_3d_unit
// Distance from a query point to a configured 3D edge, fully pipelined.
// ---------------------------------------------------------------------------
`default_nettype none

`include "point_segment_distance_3d_unit_macros.svh"

module point_segment_distance_3d_unit (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  output logic                                    busy,
  input  logic signed [psd3_pkg::COORD_W-1:0]     in_point_x,
  input  logic signed [psd3_pkg::COORD_W-1:0]     in_point_y,
  input  logic signed [psd3_pkg::COORD_W-1:0]     in_point_z,
  input  logic                                    cfg_we,
  input  logic [psd3_pkg::REG_IDX_W-1:0]          cfg_index,
  input  logic [psd3_pkg::COORD_W-1:0]            cfg_wdata,
  output logic                                    out_valid,
  output logic [psd3_pkg::OUT_W-1:0]              out_separation,
  output logic                                    out_inside_res,
  output logic [psd3_pkg::OUT_W-1:0]              out_perpendicular
);

  localparam int CW  = psd3_pkg::COORD_W;
  localparam int DW  = psd3_pkg::DIFF_W;
  localparam int PW  = psd3_pkg::PROD_W;
  localparam int S1W = psd3_pkg::SQ1_W;
  localparam int TW  = psd3_pkg::DOT_W;
  localparam int SW  = psd3_pkg::SQ_W;
  localparam int XW  = psd3_pkg::CROSS_W;
  localparam int AW  = psd3_pkg::XABS_W;
  localparam int LW  = psd3_pkg::XLO_W;
  localparam int HW  = psd3_pkg::XHI_W;
  localparam int QSW = psd3_pkg::XSQ_W;
  localparam int NW  = psd3_pkg::XX_W;
  localparam int OW  = psd3_pkg::OUT_W;

  logic accept;

  // edge corner registers and the query point
  logic signed [CW-1:0] cfg_start_r [3];
  logic signed [CW-1:0] cfg_end_r   [3];
  logic signed [CW-1:0] pt          [3];

  // stage 1: differences
  logic                 s1_valid_r;
  logic signed [DW-1:0] s1_w_nxt [3], s1_w_r [3];
  logic signed [DW-1:0] s1_u_nxt [3], s1_u_r [3];
  logic signed [DW-1:0] s1_v_nxt [3], s1_v_r [3];

  // stage 2: products
  logic                 s2_valid_r;
  logic signed [PW-1:0] s2_wv_nxt [3], s2_wv_r [3];
  logic signed [PW-1:0] s2_vv_nxt [3], s2_vv_r [3];
  logic signed [PW-1:0] s2_ww_nxt [3], s2_ww_r [3];
  logic signed [PW-1:0] s2_uu_nxt [3], s2_uu_r [3];
  logic signed [PW-1:0] s2_ca_nxt [3], s2_ca_r [3];
  logic signed [PW-1:0] s2_cb_nxt [3], s2_cb_r [3];

  // stage 3: sums and cross product
  logic                 s3_valid_r;
  logic signed [TW-1:0] s3_dot_nxt, s3_dot_r;
  logic [SW-1:0]        s3_v2_nxt, s3_v2_r;
  logic [SW-1:0]        s3_w2_nxt, s3_w2_r;
  logic [SW-1:0]        s3_u2_nxt, s3_u2_r;
  logic signed [XW-1:0] s3_x_nxt [3], s3_x_r [3];

  // stage 4: inside test, corner minimum, cross magnitudes
  logic                 s4_valid_r;
  logic                 s4_inside_nxt, s4_inside_r;
  logic [SW-1:0]        s4_mn_nxt, s4_mn_r;
  logic [SW-1:0]        s4_v2_r;
  logic [AW-1:0]        s4_xabs_nxt [3], s4_xabs_r [3];

  // stage 5: partial squares
  logic                 s5_valid_r;
  logic                 s5_inside_r;
  logic [SW-1:0]        s5_mn_r, s5_v2_r;
  logic [2*HW-1:0]      s5_hh_nxt [3], s5_hh_r [3];
  logic [HW+LW-1:0]     s5_hl_nxt [3], s5_hl_r [3];
  logic [2*LW-1:0]      s5_ll_nxt [3], s5_ll_r [3];

  // stage 6: component squares
  logic                 s6_valid_r;
  logic                 s6_inside_r;
  logic [SW-1:0]        s6_mn_r, s6_v2_r;
  logic [QSW-1:0]       s6_xsq_nxt [3], s6_xsq_r [3];

  // stage 7: squared cross length
  logic                 s7_valid_r;
  logic                 s7_inside_r;
  logic [SW-1:0]        s7_mn_r, s7_v2_r;
  logic [NW-1:0]        s7_xx_nxt, s7_xx_r;

  // stage 8: divider operands
  psd3_pkg::psd3_tag_t  s8_tag_r;
  logic [NW-1:0]        s8_num_nxt, s8_num_r;
  logic [SW-1:0]        s8_den_nxt, s8_den_r;

  // root pipe and output stage
  psd3_pkg::psd3_tag_t          root_tag;
  logic [psd3_pkg::ROOT_W-1:0]  root_val;
  logic                         out_valid_r;
  logic [OW-1:0]                out_sep_r;
  logic                         out_inside_r;
  logic [OW-1:0]                out_perp_r;

  // a new query can enter every cycle
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign pt[0] = in_point_x;
  assign pt[1] = in_point_y;
  assign pt[2] = in_point_z;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        cfg_start_r[i] <= '0;
        cfg_end_r[i]   <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        psd3_pkg::REG_START_X: cfg_start_r[0] <= cfg_wdata;
        psd3_pkg::REG_START_Y: cfg_start_r[1] <= cfg_wdata;
        psd3_pkg::REG_START_Z: cfg_start_r[2] <= cfg_wdata;
        psd3_pkg::REG_END_X:   cfg_end_r[0]   <= cfg_wdata;
        psd3_pkg::REG_END_Y:   cfg_end_r[1]   <= cfg_wdata;
        psd3_pkg::REG_END_Z:   cfg_end_r[2]   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // valid chain through the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
      s6_valid_r <= 1'b0;
      s7_valid_r <= 1'b0;
      s8_tag_r   <= '0;
    end else begin
      s1_valid_r        <= accept;
      s2_valid_r        <= s1_valid_r;
      s3_valid_r        <= s2_valid_r;
      s4_valid_r        <= s3_valid_r;
      s5_valid_r        <= s4_valid_r;
      s6_valid_r        <= s5_valid_r;
      s7_valid_r        <= s6_valid_r;
      s8_tag_r.valid    <= s7_valid_r;
      s8_tag_r.interior <= s7_inside_r;
    end
  end

  // stage 1 logic: point minus corners, edge vector
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_w_nxt[i] = DW'(pt[i]) - DW'(cfg_start_r[i]);
      s1_u_nxt[i] = DW'(pt[i]) - DW'(cfg_end_r[i]);
      s1_v_nxt[i] = DW'(cfg_end_r[i]) - DW'(cfg_start_r[i]);
    end
  end

  // stage 2 logic: one multiplier per product
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s2_wv_nxt[i] = s1_w_r[i] * s1_v_r[i];
      s2_vv_nxt[i] = s1_v_r[i] * s1_v_r[i];
      s2_ww_nxt[i] = s1_w_r[i] * s1_w_r[i];
      s2_uu_nxt[i] = s1_u_r[i] * s1_u_r[i];
    end
    s2_ca_nxt[0] = s1_w_r[1] * s1_v_r[2];
    s2_cb_nxt[0] = s1_w_r[2] * s1_v_r[1];
    s2_ca_nxt[1] = s1_w_r[2] * s1_v_r[0];
    s2_cb_nxt[1] = s1_w_r[0] * s1_v_r[2];
    s2_ca_nxt[2] = s1_w_r[0] * s1_v_r[1];
    s2_cb_nxt[2] = s1_w_r[1] * s1_v_r[0];
  end

  // stage 3 logic: dot products and cross components
  always_comb begin
    s3_dot_nxt = TW'(s2_wv_r[0]) + TW'(s2_wv_r[1]) + TW'(s2_wv_r[2]);
    s3_v2_nxt  = SW'(s2_vv_r[0][S1W-1:0]) + SW'(s2_vv_r[1][S1W-1:0])
               + SW'(s2_vv_r[2][S1W-1:0]);
    s3_w2_nxt  = SW'(s2_ww_r[0][S1W-1:0]) + SW'(s2_ww_r[1][S1W-1:0])
               + SW'(s2_ww_r[2][S1W-1:0]);
    s3_u2_nxt  = SW'(s2_uu_r[0][S1W-1:0]) + SW'(s2_uu_r[1][S1W-1:0])
               + SW'(s2_uu_r[2][S1W-1:0]);
    for (int i = 0; i < 3; i++) begin
      s3_x_nxt[i] = s2_ca_r[i] - s2_cb_r[i];
    end
  end

  // stage 4 logic: strict inside test, nearer corner, magnitudes
  always_comb begin
    s4_inside_nxt = !s3_dot_r[TW-1] && (s3_dot_r != '0)
                  && (s3_dot_r < $signed(TW'(s3_v2_r)));
    s4_mn_nxt     = (s3_w2_r < s3_u2_r) ? s3_w2_r : s3_u2_r;
    for (int i = 0; i < 3; i++) begin
      s4_xabs_nxt[i] = s3_x_r[i][XW-1] ? AW'(-s3_x_r[i]) : AW'(s3_x_r[i]);
    end
  end

  // stage 5 logic: split each magnitude into high and low halves
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s5_hh_nxt[i] = s4_xabs_r[i][AW-1:LW] * s4_xabs_r[i][AW-1:LW];
      s5_hl_nxt[i] = s4_xabs_r[i][AW-1:LW] * s4_xabs_r[i][LW-1:0];
      s5_ll_nxt[i] = s4_xabs_r[i][LW-1:0] * s4_xabs_r[i][LW-1:0];
    end
  end

  // stage 6 logic: recombine partial squares
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s6_xsq_nxt[i] = (QSW'(s5_hh_r[i]) << (2 * LW)) + (QSW'(s5_hl_r[i]) << (LW + 1))
                    + QSW'(s5_ll_r[i]);
    end
  end

  // stage 7 and 8 logic: outside items divide the squared corner distance by one
  always_comb begin
    s7_xx_nxt  = NW'(s6_xsq_r[0]) + NW'(s6_xsq_r[1]) + NW'(s6_xsq_r[2]);
    s8_num_nxt = s7_inside_r ? s7_xx_r : NW'(s7_mn_r);
    s8_den_nxt = s7_inside_r ? s7_v2_r : SW'(1);
  end

  // front stage data registers
  always_ff @(posedge clk) begin
    s1_w_r      <= s1_w_nxt;
    s1_u_r      <= s1_u_nxt;
    s1_v_r      <= s1_v_nxt;
    s2_wv_r     <= s2_wv_nxt;
    s2_vv_r     <= s2_vv_nxt;
    s2_ww_r     <= s2_ww_nxt;
    s2_uu_r     <= s2_uu_nxt;
    s2_ca_r     <= s2_ca_nxt;
    s2_cb_r     <= s2_cb_nxt;
    s3_dot_r    <= s3_dot_nxt;
    s3_v2_r     <= s3_v2_nxt;
    s3_w2_r     <= s3_w2_nxt;
    s3_u2_r     <= s3_u2_nxt;
    s3_x_r      <= s3_x_nxt;
    s4_inside_r <= s4_inside_nxt;
    s4_mn_r     <= s4_mn_nxt;
    s4_v2_r     <= s3_v2_r;
    s4_xabs_r   <= s4_xabs_nxt;
    s5_inside_r <= s4_inside_r;
    s5_mn_r     <= s4_mn_r;
    s5_v2_r     <= s4_v2_r;
    s5_hh_r     <= s5_hh_nxt;
    s5_hl_r     <= s5_hl_nxt;
    s5_ll_r     <= s5_ll_nxt;
    s6_inside_r <= s5_inside_r;
    s6_mn_r     <= s5_mn_r;
    s6_v2_r     <= s5_v2_r;
    s6_xsq_r    <= s6_xsq_nxt;
    s7_inside_r <= s6_inside_r;
    s7_mn_r     <= s6_mn_r;
    s7_v2_r     <= s6_v2_r;
    s7_xx_r     <= s7_xx_nxt;
    s8_num_r    <= s8_num_nxt;
    s8_den_r    <= s8_den_nxt;
  end

  // quotient and square root
  psd3_root_pipe u_root_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tag   (s8_tag_r),
    .in_num   (s8_num_r),
    .in_den   (s8_den_r),
    .out_tag  (root_tag),
    .out_root (root_val)
  );

  // result register, one-cycle strobe per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= root_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_sep_r    <= OW'(root_val);
    out_inside_r <= root_tag.interior;
    out_perp_r   <= root_tag.interior ? OW'(root_val) : '0;
  end

  assign out_valid         = out_valid_r;
  assign out_separation    = out_sep_r;
  assign out_inside_res    = out_inside_r;
  assign out_perpendicular = out_perp_r;

  // checks
  `PSD3_ASSERT_NEXT(a_accept_enters, clk, rst_n, accept, s1_valid_r)
  `PSD3_ASSERT_IMPLY(a_inside_needs_edge, clk, rst_n, s4_valid_r && s4_inside_r, s4_v2_r != '0)
  `PSD3_ASSERT_IMPLY(a_result_from_start, clk, rst_n, out_valid, $past(start, psd3_pkg::PIPE_LAT))
  `PSD3_ASSERT_IMPLY(a_perp_zero_outside, clk, rst_n, out_valid && !out_inside_res, out_perpendicular == '0)
  `PSD3_ASSERT_IMPLY(a_perp_inside_same, clk, rst_n, out_valid && out_inside_res, out_perpendicular == out_separation)

endmodule

`default_nettype wire

/* dv/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the point to 3D edge distance unit: a queued
// driver sends query points, mostly with random gaps, an exact integer predictor
// computes each result, and a monitor compares every strobed result.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_W   = psd3_pkg::COORD_W;
  localparam int OUT_W     = psd3_pkg::OUT_W;
  localparam int REG_IDX_W = psd3_pkg::REG_IDX_W;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = psd3_pkg::PIPE_LAT + 20;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [OUT_W-1:0] DIST_MAX = {OUT_W{1'b1}};

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } query_t;

  typedef struct packed {
    logic [OUT_W-1:0] separation;
    logic             interior;
    logic [OUT_W-1:0] perpendicular;
  } distance_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [COORD_W-1:0] in_point_x = '0;
  logic signed [COORD_W-1:0] in_point_y = '0;
  logic signed [COORD_W-1:0] in_point_z = '0;
  logic cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0] cfg_wdata = '0;
  logic out_valid;
  logic [OUT_W-1:0] out_separation;
  logic out_inside_res;
  logic [OUT_W-1:0] out_perpendicular;

  // local copy of the edge corners
  logic signed [COORD_W-1:0] edge_regs [6];

  query_t    pending_queries[$];
  distance_t expected_distances[$];

  int  gap_left = 0;
  bit  gaps_on = 1'b1;
  int  queries_sent = 0;
  int  results_checked = 0;
  int  inside_seen = 0;
  int  mismatches = 0;
  int  quiet_cycles = 0;
  int  edges_used = 0;
  query_t next_query;

  point_segment_distance_3d_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_separation(out_separation),
    .out_inside_res(out_inside_res), .out_perpendicular(out_perpendicular)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // floor square root, bit by bit
  function automatic logic [255:0] floor_sqrt(input logic [255:0] a);
    logic [255:0] r;
    logic [255:0] c;
    r = '0;
    for (int i = 79; i >= 0; i--) begin
      c = r;
      c[i] = 1'b1;
      if (c * c <= a) r = c;
    end
    return r;
  endfunction

  function automatic logic [OUT_W-1:0] clip_dist(input logic [255:0] d);
    if (d > 256'(DIST_MAX)) return DIST_MAX;
    return d[OUT_W-1:0];
  endfunction

  // exact edge distance on the raw fixed-point values
  function automatic distance_t edge_distance(input logic signed [COORD_W-1:0] px,
                                              input logic signed [COORD_W-1:0] py,
                                              input logic signed [COORD_W-1:0] pz);
    logic signed [255:0] p [3];
    logic signed [255:0] s [3];
    logic signed [255:0] e [3];
    logic signed [255:0] w [3];
    logic signed [255:0] u [3];
    logic signed [255:0] v [3];
    logic signed [255:0] cx, cy, cz, proj, vlen2, cross2, wl2, ul2;
    distance_t r;
    p[0] = px; p[1] = py; p[2] = pz;
    for (int i = 0; i < 3; i++) begin
      s[i] = edge_regs[i];
      e[i] = edge_regs[3 + i];
      w[i] = p[i] - s[i];
      u[i] = p[i] - e[i];
      v[i] = e[i] - s[i];
    end
    proj  = w[0] * v[0] + w[1] * v[1] + w[2] * v[2];
    vlen2 = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
    if (proj > 0 && proj < vlen2) begin
      cx = w[1] * v[2] - w[2] * v[1];
      cy = w[2] * v[0] - w[0] * v[2];
      cz = w[0] * v[1] - w[1] * v[0];
      cross2 = cx * cx + cy * cy + cz * cz;
      r.separation    = clip_dist(floor_sqrt(cross2 / vlen2));
      r.interior      = 1'b1;
      r.perpendicular = r.separation;
    end else begin
      wl2 = w[0] * w[0] + w[1] * w[1] + w[2] * w[2];
      ul2 = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
      r.separation    = clip_dist(floor_sqrt(wl2 < ul2 ? wl2 : ul2));
      r.interior      = 1'b0;
      r.perpendicular = '0;
    end
    return r;
  endfunction

  // driver: one transfer per accepted start, random gaps between items while gaps are on
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_distances.push_back(edge_distance(in_point_x, in_point_y, in_point_z));
        queries_sent++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_queries.size() > 0) begin
          next_query = pending_queries.pop_front();
          in_point_x <= next_query.x;
          in_point_y <= next_query.y;
          in_point_z <= next_query.z;
          start <= 1'b1;
          gap_left = gaps_on ? $urandom_range(0, 9) : 0;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each strobed result with the oldest prediction
  always @(posedge clk) begin
    distance_t want;
    if (rst_n && out_valid) begin
      if (expected_distances.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result sep=%h inside=%b perp=%h",
                   out_separation, out_inside_res, out_perpendicular);
      end else begin
        want = expected_distances.pop_front();
        results_checked++;
        if (want.interior) inside_seen++;
        if (out_separation !== want.separation || out_inside_res !== want.interior ||
            out_perpendicular !== want.perpendicular) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected sep=%h inside=%b perp=%h, got sep=%h inside=%b perp=%h",
                     want.separation, want.interior, want.perpendicular,
                     out_separation, out_inside_res, out_perpendicular);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired");
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx < 6) edge_regs[idx] = data;
  endtask

  task automatic set_edge(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                          input logic [COORD_W-1:0] sz, input logic [COORD_W-1:0] ex,
                          input logic [COORD_W-1:0] ey, input logic [COORD_W-1:0] ez);
    write_reg(psd3_pkg::REG_START_X, sx);
    write_reg(psd3_pkg::REG_START_Y, sy);
    write_reg(psd3_pkg::REG_START_Z, sz);
    write_reg(psd3_pkg::REG_END_X, ex);
    write_reg(psd3_pkg::REG_END_Y, ey);
    write_reg(psd3_pkg::REG_END_Z, ez);
    if ($urandom_range(0, 2) == 0) begin
      write_reg(REG_SPARE_LO, $urandom());
      write_reg(REG_SPARE_HI, $urandom());
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    edges_used++;
  endtask

  task automatic send(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                      input logic [COORD_W-1:0] z);
    query_t q;
    q.x = x; q.y = y; q.z = z;
    pending_queries.push_back(q);
  endtask

  task automatic wait_drained();
    while (pending_queries.size() > 0 || expected_distances.size() > 0 || start)
      @(posedge clk);
  endtask

  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(0, 20)) - 10);
      3: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
      default: return $urandom();
    endcase
  endfunction

  // point at step k/16 along the edge, with no, a small or a large random offset
  function automatic logic [COORD_W-1:0] near_edge(input int axis, input int k);
    logic signed [63:0] s, e, d;
    s = edge_regs[axis];
    e = edge_regs[3 + axis];
    d = ((e - s) * k) >>> 4;
    case ($urandom_range(0, 2))
      0: return 32'(s + d);
      1: return 32'(s + d + $signed({{48{1'b0}}, 16'($urandom())}) - 64'sd32768);
      default: return 32'(s + d + $signed(64'($urandom())) - 64'sd2147483648);
    endcase
  endfunction

  initial begin
    int k;
    for (int i = 0; i < 6; i++) edge_regs[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset edge is degenerate at the origin
    gaps_on = 1'b0;
    send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send(32'h0, 32'h0, 32'h0);
    send(32'h0001_0000, 32'hFFFF_FFFF, 32'h0);
    wait_drained();

    // unit-scale edge along x: inside, level with both corners, beyond both ends
    set_edge(32'h0, 32'h0, 32'h0, 32'h000A_0000, 32'h0, 32'h0);
    gaps_on = 1'b1;
    send(32'h0005_0000, 32'h0003_0000, 32'h0004_0000);
    send(32'h0000_0000, 32'h0003_0000, 32'h0000_0000);
    send(32'h000A_0000, 32'h0000_0000, 32'h0004_0000);
    send(32'hFFFE_0000, 32'h0001_0000, 32'h0000_0000);
    send(32'h000C_0000, 32'h0000_0000, 32'h0001_0000);
    send(32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
    send(32'h0009_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send(32'h0005_0000, 32'h0000_0000, 32'h0000_0000);
    wait_drained();

    // longest edge, corner to corner of the coordinate range
    set_edge(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send(32'h0, 32'h0, 32'h0);
    send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    wait_drained();

    // degenerate edge away from the origin
    set_edge(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678,
             32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);
    send(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);
    send($urandom(), $urandom(), $urandom());
    wait_drained();

    // random edges, most points placed along the edge
    for (int ph = 0; ph < 12; ph++) begin
      case ($urandom_range(0, 4))
        0: set_edge(pick_coord(), pick_coord(), pick_coord(),
                    pick_coord(), pick_coord(), pick_coord());
        1: begin
          k = $urandom();
          set_edge(k, 32'(k + 1), k, k, k, 32'(k - 1));
        end
        2: set_edge(32'($urandom_range(0, 32'h0040_0000)), $urandom_range(0, 32'h0040_0000),
                    $urandom_range(0, 32'h0040_0000), $urandom_range(0, 32'h0040_0000),
                    $urandom_range(0, 32'h0040_0000), $urandom_range(0, 32'h0040_0000));
        default: set_edge($urandom(), $urandom(), $urandom(),
                          $urandom(), $urandom(), $urandom());
      endcase
      gaps_on = (ph % 4) != 3;
      for (int n = 0; n < 95; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          send(pick_coord(), pick_coord(), pick_coord());
        end else begin
          k = $urandom_range(0, 20) - 2;
          send(near_edge(0, k), near_edge(1, k), near_edge(2, k));
        end
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d of %0d queries over %0d edges, %0d with the projection inside",
             results_checked, queries_sent, edges_used, inside_seen);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0 && expected_distances.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
+incdir+rtl
rtl/psd3_pkg.sv
rtl/psd3_root_pipe.sv
rtl/point_segment_distance_3d_unit.sv
dv/tb.sv
